FILE: hdl/assert_macros.svh
// Assertion macros shared by the list RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/bsl_pkg.sv
// Shared types and constants for the bounded sequential list.
// No dependencies; used by bsl_cell and bounded_sequential_list.
`timescale 1ns / 1ps

package bsl_pkg;

    // List geometry, fixed by the widths of the request and result fields.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;

    // Request codes.
    localparam logic [3:0] REQ_CLEAR     = 4'd0;
    localparam logic [3:0] REQ_APPEND    = 4'd1;
    localparam logic [3:0] REQ_POP_END   = 4'd2;
    localparam logic [3:0] REQ_INS_FRONT = 4'd3;
    localparam logic [3:0] REQ_POP_FRONT = 4'd4;
    localparam logic [3:0] REQ_RM_POS    = 4'd5;
    localparam logic [3:0] REQ_RM_VAL    = 4'd6;
    localparam logic [3:0] REQ_REVERSE   = 4'd7;
    localparam logic [3:0] REQ_READ      = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Action broadcast along the row of cells.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHR,
        CELL_SHL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [IDX_W-1:0]         at;
        logic signed [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

FILE: hdl/bsl_cell.sv
// One storage cell of the list: a single entry and its neighbour selection.
// Depends on bsl_pkg for the broadcast command type.
`timescale 1ns / 1ps

module bsl_cell
(
    input  logic                                clk,
    input  logic [bsl_pkg::IDX_W-1:0]           idx,
    input  bsl_pkg::cell_cmd_t                  cmd,
    input  logic signed [bsl_pkg::DATA_W-1:0]   left,
    input  logic signed [bsl_pkg::DATA_W-1:0]   right,
    output logic signed [bsl_pkg::DATA_W-1:0]   q
);

    logic signed [bsl_pkg::DATA_W-1:0] entry_reg;
    logic signed [bsl_pkg::DATA_W-1:0] entry_next;

    // Choose the new entry from the broadcast action and this cell's place in the row.
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            bsl_pkg::CELL_WRITE:
            begin
                if (idx == cmd.at)
                begin
                    entry_next = cmd.data;
                end
            end
            bsl_pkg::CELL_SHR:
            begin
                entry_next = (idx == '0) ? cmd.data : left;
            end
            bsl_pkg::CELL_SHL:
            begin
                if (idx >= cmd.at)
                begin
                    entry_next = right;
                end
            end
            bsl_pkg::CELL_ROT:
            begin
                if (idx < cmd.at)
                begin
                    entry_next = right;
                end
                else if (idx == cmd.at)
                begin
                    entry_next = cmd.data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The entry itself carries no reset; it is read only after being written.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

FILE: hdl/bounded_sequential_list.sv
// A list of up to DEPTH signed 32-bit entries held in a row of cells, with its control.
// Depends on bsl_pkg, bsl_cell and assert_macros.svh.
//
// A request is taken when start is high and busy is low, and its result appears on the
// result ports for exactly one cycle, marked by done; the receiver cannot stall it, so it
// must capture the result in that cycle. Clear, append, pop end, insert front, pop front,
// remove position and read give their result in the next cycle and may follow one another
// in consecutive cycles. Reverse steps one rotation through the cell row per cycle and
// holds busy until the last one. Remove value scans the row one entry per cycle, either
// advancing or removing a match, until the scan reaches the count. Requests on an empty
// or full list, or with a position at or beyond the count, return at once with a status.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_sequential_list
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [3:0]                          req_type,
    input  logic signed [bsl_pkg::DATA_W-1:0]   data_value,
    input  logic [bsl_pkg::IDX_W-1:0]           position,
    output logic [1:0]                          status,
    output logic [bsl_pkg::CNT_W-1:0]           element_count,
    output logic signed [bsl_pkg::DATA_W-1:0]   last_value,
    output logic signed [bsl_pkg::DATA_W-1:0]   read_value,
    output logic                                is_empty,
    output logic                                is_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMVAL,
        S_REV
    } state_t;

    state_t                             state_reg, state_next;
    logic [bsl_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [bsl_pkg::CNT_W-1:0]          scan_reg, scan_next;
    logic [bsl_pkg::IDX_W-1:0]          lim_reg, lim_next;
    logic signed [bsl_pkg::DATA_W-1:0]  val_reg, val_next;
    logic                               done_reg, done_next;
    logic [1:0]                         status_reg, status_next;
    logic signed [bsl_pkg::DATA_W-1:0]  read_reg, read_next;

    bsl_pkg::cell_cmd_t                 cmd;
    logic signed [bsl_pkg::DATA_W-1:0]  cell_q [bsl_pkg::DEPTH];
    logic [bsl_pkg::CNT_W-1:0]          count_dec;
    logic                               list_empty;
    logic                               list_full;

    assign count_dec  = count_reg - 1'b1;
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == bsl_pkg::CNT_W'(bsl_pkg::DEPTH));

    // Row of cells; each takes its neighbours' entries for the shift and rotate actions.
    for (genvar i = 0; i < bsl_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [bsl_pkg::DATA_W-1:0] left_d;
        logic signed [bsl_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cmd.data;
        end
        else
        begin : g_inner_l
            assign left_d = cell_q[i-1];
        end

        if (i == bsl_pkg::DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[i];
        end
        else
        begin : g_inner_r
            assign right_d = cell_q[i+1];
        end

        bsl_cell u_cell
        (
            .clk   (clk),
            .idx   (bsl_pkg::IDX_W'(i)),
            .cmd   (cmd),
            .left  (left_d),
            .right (right_d),
            .q     (cell_q[i])
        );
    end

    // Request decode and the sequencer for the multi-cycle requests.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        lim_next    = lim_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        read_next   = read_reg;
        cmd.op      = bsl_pkg::CELL_HOLD;
        cmd.at      = '0;
        cmd.data    = data_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = bsl_pkg::ST_OK;
                    read_next   = '0;
                    unique case (req_type)
                        bsl_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        bsl_pkg::REQ_APPEND:
                        begin
                            if (list_full)
                            begin
                                status_next = bsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = bsl_pkg::CELL_WRITE;
                                cmd.at     = count_reg[bsl_pkg::IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bsl_pkg::REQ_POP_END:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_dec;
                            end
                        end
                        bsl_pkg::REQ_INS_FRONT:
                        begin
                            if (list_full)
                            begin
                                status_next = bsl_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = bsl_pkg::CELL_SHR;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bsl_pkg::REQ_POP_FRONT:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = bsl_pkg::CELL_SHL;
                                cmd.at     = '0;
                                count_next = count_dec;
                            end
                        end
                        bsl_pkg::REQ_RM_POS:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else if ({1'b0, position} >= count_reg)
                            begin
                                status_next = bsl_pkg::ST_RANGE;
                            end
                            else
                            begin
                                cmd.op     = bsl_pkg::CELL_SHL;
                                cmd.at     = position;
                                count_next = count_dec;
                            end
                        end
                        bsl_pkg::REQ_RM_VAL:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_RMVAL;
                                scan_next  = '0;
                                val_next   = data_value;
                            end
                        end
                        bsl_pkg::REQ_REVERSE:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else if (count_reg != bsl_pkg::CNT_W'(1))
                            begin
                                done_next  = 1'b0;
                                state_next = S_REV;
                                lim_next   = count_dec[bsl_pkg::IDX_W-1:0];
                            end
                        end
                        bsl_pkg::REQ_READ:
                        begin
                            if (list_empty)
                            begin
                                status_next = bsl_pkg::ST_EMPTY;
                            end
                            else if ({1'b0, position} >= count_reg)
                            begin
                                status_next = bsl_pkg::ST_RANGE;
                            end
                            else
                            begin
                                read_next = cell_q[position];
                            end
                        end
                        default:
                        begin
                            status_next = bsl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RMVAL:
            begin
                // Each step either drops a matching entry or moves the scan on.
                if (scan_reg >= count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = bsl_pkg::ST_OK;
                    read_next   = '0;
                    state_next  = S_IDLE;
                end
                else if (cell_q[scan_reg[bsl_pkg::IDX_W-1:0]] == val_reg)
                begin
                    cmd.op     = bsl_pkg::CELL_SHL;
                    cmd.at     = scan_reg[bsl_pkg::IDX_W-1:0];
                    count_next = count_dec;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_REV:
            begin
                // Move the head entry to the shrinking tail boundary, shifting the rest left.
                cmd.op   = bsl_pkg::CELL_ROT;
                cmd.at   = lim_reg;
                cmd.data = cell_q[0];
                if (lim_reg == bsl_pkg::IDX_W'(1))
                begin
                    done_next   = 1'b1;
                    status_next = bsl_pkg::ST_OK;
                    read_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lim_next = lim_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            scan_reg   <= '0;
            lim_reg    <= '0;
            val_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= bsl_pkg::ST_OK;
            read_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            lim_reg    <= lim_next;
            val_reg    <= val_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            read_reg   <= read_next;
        end
    end

    // Result ports; count-derived fields follow the list state after the transfer.
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign read_value    = read_reg;
    assign element_count = count_reg;
    assign last_value    = list_empty ? '0 : cell_q[count_dec[bsl_pkg::IDX_W-1:0]];
    assign is_empty      = list_empty;
    assign is_full       = list_full;

    // The count never passes the depth of the row.
    `ASSERT_ALWAYS(a_count_bound, count_reg <= bsl_pkg::CNT_W'(bsl_pkg::DEPTH), "count above depth")
    // A result follows only an accepted request or the end of a multi-cycle request.
    `ASSERT_SAME(a_done_cause, done_reg, $past(start) || $past(state_reg != S_IDLE), "stray done")
    // Compaction never grows the list.
    `ASSERT_NEXT(a_rmval_shrink, state_reg == S_RMVAL, count_reg <= $past(count_reg), "rmval grew")
    // Reversal keeps the count unchanged.
    `ASSERT_NEXT(a_rev_count, state_reg == S_REV, $stable(count_reg), "reverse changed count")
    // A non-zero read value comes only with an ok status.
    `ASSERT_SAME(a_read_ok, done_reg && (read_reg != '0), status_reg == bsl_pkg::ST_OK, "read bad")

endmodule

FILE: verif/bsl_checker.sv
`timescale 1ns / 1ps
// Result checker for bounded_sequential_list: keeps its own copy of the list, predicts
// the outcome of every accepted request and compares each strobed result field by field.
// Depends on bsl_pkg; instantiated beside the block by bounded_sequential_list_tb.

module bsl_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [3:0]                          req_type,
    input  logic signed [bsl_pkg::DATA_W-1:0]   data_value,
    input  logic [bsl_pkg::IDX_W-1:0]           position,
    input  logic [1:0]                          status,
    input  logic [bsl_pkg::CNT_W-1:0]           element_count,
    input  logic signed [bsl_pkg::DATA_W-1:0]   last_value,
    input  logic signed [bsl_pkg::DATA_W-1:0]   read_value,
    input  logic                                is_empty,
    input  logic                                is_full,
    output int unsigned                         fail_count,
    output int unsigned                         pending,
    output int unsigned                         compared
);

    typedef struct {
        logic [1:0]                         status;
        logic [bsl_pkg::CNT_W-1:0]          count;
        logic signed [bsl_pkg::DATA_W-1:0]  last;
        logic signed [bsl_pkg::DATA_W-1:0]  rd;
        logic                               empty;
        logic                               full;
    } list_outcome_t;

    // Mirror of the list contents and its length.
    logic signed [bsl_pkg::DATA_W-1:0] cells [bsl_pkg::DEPTH];
    int                                n_cells;

    // Outcomes predicted for requests whose results have not yet been strobed.
    list_outcome_t            outcomes [$];

    int unsigned              mismatches;
    int unsigned              n_compared;

    // Applies one request to the mirror and returns the result it should give.
    function automatic list_outcome_t serve_request(input logic [3:0] req,
                                                    input logic signed [bsl_pkg::DATA_W-1:0] val,
                                                    input logic [bsl_pkg::IDX_W-1:0] pos);
        list_outcome_t                     o;
        int                                at;
        int                                kept;
        logic signed [bsl_pkg::DATA_W-1:0] tmp;
        o.status = bsl_pkg::ST_OK;
        o.rd     = '0;
        case (req)
            bsl_pkg::REQ_CLEAR:
            begin
                n_cells = 0;
            end
            bsl_pkg::REQ_APPEND:
            begin
                if (n_cells >= bsl_pkg::DEPTH)
                    o.status = bsl_pkg::ST_FULL;
                else
                begin
                    cells[n_cells] = val;
                    n_cells++;
                end
            end
            bsl_pkg::REQ_POP_END:
            begin
                if (n_cells == 0)
                    o.status = bsl_pkg::ST_EMPTY;
                else
                    n_cells--;
            end
            bsl_pkg::REQ_INS_FRONT:
            begin
                if (n_cells >= bsl_pkg::DEPTH)
                    o.status = bsl_pkg::ST_FULL;
                else
                begin
                    for (int i = n_cells; i > 0; i--)
                        cells[i] = cells[i-1];
                    cells[0] = val;
                    n_cells++;
                end
            end
            bsl_pkg::REQ_POP_FRONT, bsl_pkg::REQ_RM_POS:
            begin
                at = (req == bsl_pkg::REQ_POP_FRONT) ? 0 : int'(pos);
                if (n_cells == 0)
                    o.status = bsl_pkg::ST_EMPTY;
                else if (at >= n_cells)
                    o.status = bsl_pkg::ST_RANGE;
                else
                begin
                    for (int i = at; i + 1 < n_cells; i++)
                        cells[i] = cells[i+1];
                    n_cells--;
                end
            end
            bsl_pkg::REQ_RM_VAL:
            begin
                if (n_cells == 0)
                    o.status = bsl_pkg::ST_EMPTY;
                else
                begin
                    kept = 0;
                    for (int i = 0; i < n_cells; i++)
                    begin
                        if (cells[i] != val)
                        begin
                            cells[kept] = cells[i];
                            kept++;
                        end
                    end
                    n_cells = kept;
                end
            end
            bsl_pkg::REQ_REVERSE:
            begin
                if (n_cells == 0)
                    o.status = bsl_pkg::ST_EMPTY;
                else
                begin
                    for (int i = 0; i < n_cells / 2; i++)
                    begin
                        tmp                  = cells[i];
                        cells[i]             = cells[n_cells-1-i];
                        cells[n_cells-1-i]   = tmp;
                    end
                end
            end
            bsl_pkg::REQ_READ:
            begin
                if (n_cells == 0)
                    o.status = bsl_pkg::ST_EMPTY;
                else if (int'(pos) >= n_cells)
                    o.status = bsl_pkg::ST_RANGE;
                else
                    o.rd = cells[pos];
            end
            default:
            begin
                // Unused request codes leave the list alone.
            end
        endcase
        o.count = n_cells[bsl_pkg::CNT_W-1:0];
        o.last  = (n_cells > 0) ? cells[n_cells-1] : '0;
        o.empty = (n_cells == 0);
        o.full  = (n_cells == bsl_pkg::DEPTH);
        return o;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Results are consumed before new requests are queued; a result always belongs to
    // a request accepted at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        list_outcome_t want;
        if (!rst_n)
        begin
            n_cells = 0;
            outcomes.delete();
            mismatches = 0;
            n_compared = 0;
            fail_count <= 0;
            pending    <= 0;
            compared   <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (outcomes.size() == 0)
                begin
                    $error("result strobed with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = outcomes.pop_front();
                    check_field("status", want.status, status);
                    check_field("element_count", want.count, element_count);
                    check_field("last_value", want.last, last_value);
                    check_field("read_value", want.rd, read_value);
                    check_field("is_empty", want.empty, is_empty);
                    check_field("is_full", want.full, is_full);
                    n_compared++;
                end
            end
            if (start && !busy)
                outcomes.push_back(serve_request(req_type, data_value, position));
            fail_count <= mismatches;
            pending    <= outcomes.size();
            compared   <= n_compared;
        end
    end

endmodule

FILE: verif/bounded_sequential_list_tb.sv
`timescale 1ns / 1ps
// Testbench top for bounded_sequential_list: drives a directed opening and then bursts of
// random requests, and gives the verdict from the failure count of bsl_checker.
// Depends on bsl_pkg, bsl_checker and the block itself.

module bounded_sequential_list_tb;

    localparam int         N_RANDOM      = 1080;
    localparam int         IDLE_LIMIT    = 1000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         DRAIN_EVERY   = 250;
    localparam logic [3:0] REQ_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] REQ_LAST_UNUSED  = 4'd15;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               start      = 1'b0;
    logic [3:0]                         req_type   = '0;
    logic signed [bsl_pkg::DATA_W-1:0]  data_value = '0;
    logic [bsl_pkg::IDX_W-1:0]          position   = '0;
    logic                               busy;
    logic                               done;
    logic [1:0]                         status;
    logic [bsl_pkg::CNT_W-1:0]          element_count;
    logic signed [bsl_pkg::DATA_W-1:0]  last_value;
    logic signed [bsl_pkg::DATA_W-1:0]  read_value;
    logic                               is_empty;
    logic                               is_full;
    int unsigned                        fail_count;
    int unsigned                        pending;
    int unsigned                        compared;
    int unsigned                        requests_sent = 0;
    int unsigned                        idle_cycles   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_sequential_list uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .req_type      (req_type),
        .data_value    (data_value),
        .position      (position),
        .status        (status),
        .element_count (element_count),
        .last_value    (last_value),
        .read_value    (read_value),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    bsl_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .req_type      (req_type),
        .data_value    (data_value),
        .position      (position),
        .status        (status),
        .element_count (element_count),
        .last_value    (last_value),
        .read_value    (read_value),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .fail_count    (fail_count),
        .pending       (pending),
        .compared      (compared)
    );

    // Watchdog: ends the run if neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAIL bounded_sequential_list");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Presents one request and returns at the edge on which its transfer takes place.
    task automatic transfer(input logic [3:0] r, input logic signed [bsl_pkg::DATA_W-1:0] v,
                            input logic [bsl_pkg::IDX_W-1:0] p);
        start      <= 1'b1;
        req_type   <= r;
        data_value <= v;
        position   <= p;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
    endtask

    // Holds requests back until every outstanding result has been strobed.
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Values for inserts and removals: a small pool makes duplicates and hits likely.
    function automatic logic signed [bsl_pkg::DATA_W-1:0] pick_value();
        logic signed [bsl_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 4)) - 2;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Chooses a request code for the current burst: growing, shrinking or mixed.
    function automatic logic [3:0] pick_request(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode < 40 && roll < 85)
            return roll[0] ? bsl_pkg::REQ_APPEND : bsl_pkg::REQ_INS_FRONT;
        if (mode >= 40 && mode < 75 && roll < 80)
            return 4'($urandom_range(bsl_pkg::REQ_POP_END, bsl_pkg::REQ_READ));
        if (roll < 3)
            return bsl_pkg::REQ_CLEAR;
        if (roll < 80)
            return 4'($urandom_range(bsl_pkg::REQ_APPEND, bsl_pkg::REQ_READ));
        return 4'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
    endfunction

    initial
    begin
        int                         burst;
        int                         mode;
        int unsigned                directed;
        int unsigned                next_drain;
        logic [bsl_pkg::IDX_W-1:0]  p;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear, every request that needs entries, and an unused code, on an empty list.
        transfer(bsl_pkg::REQ_CLEAR, '0, '0);
        transfer(bsl_pkg::REQ_POP_END, '0, '0);
        transfer(bsl_pkg::REQ_POP_FRONT, '0, '0);
        transfer(bsl_pkg::REQ_RM_POS, '0, '0);
        transfer(bsl_pkg::REQ_RM_VAL, '0, '0);
        transfer(bsl_pkg::REQ_REVERSE, '0, '0);
        transfer(bsl_pkg::REQ_READ, '0, '0);
        transfer(REQ_FIRST_UNUSED, '1, '1);

        // Build a short list from extreme values, starting with insert front on empty.
        transfer(bsl_pkg::REQ_INS_FRONT, 32'h8000_0000, '0);
        transfer(bsl_pkg::REQ_APPEND, 32'h7fff_ffff, '0);
        transfer(bsl_pkg::REQ_APPEND, '1, '0);
        transfer(bsl_pkg::REQ_INS_FRONT, '0, '0);
        transfer(bsl_pkg::REQ_APPEND, '1, '0);

        // Reads in range and beyond the count, reverse, and the removals.
        transfer(bsl_pkg::REQ_READ, '0, 4'd0);
        transfer(bsl_pkg::REQ_READ, '0, 4'd4);
        transfer(bsl_pkg::REQ_READ, '0, 4'd15);
        transfer(bsl_pkg::REQ_REVERSE, '0, '0);
        transfer(bsl_pkg::REQ_RM_POS, '0, 4'd5);
        transfer(bsl_pkg::REQ_RM_VAL, '1, '0);
        transfer(bsl_pkg::REQ_RM_VAL, 32'sd77, '0);
        transfer(bsl_pkg::REQ_RM_POS, '0, 4'd1);
        transfer(bsl_pkg::REQ_POP_FRONT, '0, '0);
        transfer(bsl_pkg::REQ_POP_END, '0, '0);
        transfer(REQ_LAST_UNUSED, '0, '0);
        directed = requests_sent;
        wait_all_results();

        // Random bursts; gaps between some bursts, others follow back to back.
        next_drain = requests_sent + DRAIN_EVERY;
        while (requests_sent < directed + N_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            mode  = $urandom_range(0, 99);
            repeat (burst)
            begin
                p = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
                transfer(pick_request(mode), pick_value(), p);
            end
            if (requests_sent >= next_drain)
            begin
                wait_all_results();
                next_drain = requests_sent + DRAIN_EVERY;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed, the rest in random grow, shrink",
                 requests_sent, directed);
        $display("and mixed bursts); %0d results were compared.", compared);
        if (fail_count == 0)
            $display("PASS bounded_sequential_list");
        else
            $display("FAIL bounded_sequential_list");
        $finish;
    end

endmodule
